>>> hw/rtl/rrle_pkg.sv
// Package for the ring leader election node: item types, codes and helpers.
// No dependencies; every other file refers to it by scoped names.
package rrle_pkg;

  // Ring size limits
  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = $clog2(MAX_NODES + 1);

  // Depth of the queue between front and back
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_MSG   = 1'b1;

  // Result kind codes
  localparam logic KIND_MSG    = 1'b0;
  localparam logic KIND_LEADER = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SELF_ID    = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd1;

  // Reset values of the configuration registers
  localparam logic [NODE_W-1:0]  SELF_ID_RST    = '0;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(MAX_NODES);
  localparam logic [COUNT_W-1:0] COUNT_MIN      = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = COUNT_W'(MAX_NODES);

  typedef logic [MAX_NODES-1:0] node_set_t;

  // One input request
  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] msg_origin;
    logic              msg_bit;
    logic              random_bit;
  } in_item_t;

  // One result request
  typedef struct packed {
    logic              out_kind;
    logic [NODE_W-1:0] out_origin;
    logic              out_bit;
    logic              last;
  } out_item_t;

  // Up to two results caused by one input, in order
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } job_t;

  // Mask of nodes below the effective count
  function automatic node_set_t count_mask(input logic [COUNT_W-1:0] n);
    node_set_t m;
    for (int i = 0; i < MAX_NODES; i++) begin
      m[i] = (COUNT_W'(i) < n);
    end
    return m;
  endfunction

  // Index of the single set bit of a one-hot set
  function automatic logic [NODE_W-1:0] onehot_index(input node_set_t s);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (s[i]) begin
        idx = idx | NODE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/ring_random_leader_election_node.sv
// Top level of one ring node of a randomized leader election.
// Instantiates rrle_front, rrle_fifo and rrle_back; uses rrle_pkg.
//
// Usage:
//   Input queue: drive in_item and raise push; the request is taken at a
//   clock edge where push is high and full is low. A start request sends
//   this node's bit; a message request is recorded, forwarded unless it is
//   this node's own, and may close the round (leader or fresh bit).
//   Result queue: while empty is low, out_item holds the oldest result;
//   raise pop to take it. The last flag marks the final result of a request.
//   Configuration: cfg_index 0 is self_id, 1 is node_count; cfg_ready is
//   always high, write only while the node is idle.
//   A request's results pass through the job queue, then the result register.
//   Throughput: one request per cycle while full is low, when each yields one
//   result; a request with two results holds the result register for both in
//   turn. The front updates state and hands a job to a two-entry queue.
//   When pop is held low, the queue and result register fill and full rises.
//   Reset (rst_n low, synchronous) clears the heard and candidate sets, the
//   round flag and the queues, makes every node a participant and restores
//   self_id 0 and node_count 16.
module ring_random_leader_election_node (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  rrle_pkg::in_item_t           in_item,
  output logic                         empty,
  input  logic                         pop,
  output rrle_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [rrle_pkg::COUNT_W-1:0] cfg_data
);

  logic           in_accept;
  logic           job_push, job_pop, job_empty;
  rrle_pkg::job_t job_in, job_out;

  assign cfg_ready = 1'b1;
  assign in_accept = push && !full;

  // Classify requests and update election state
  rrle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_item   (in_item),
    .job_push  (job_push),
    .job       (job_in)
  );

  // Decouple front and back
  rrle_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_job (job_in),
    .full   (full),
    .rd_en  (job_pop),
    .rd_job (job_out),
    .empty  (job_empty)
  );

  // Deliver results one at a time
  rrle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/rrle_front.sv
// Front end of the election node: configuration, election state, classification.
// Turns each accepted request into a job of up to two results; uses rrle_pkg.
module rrle_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [rrle_pkg::COUNT_W-1:0] cfg_data,
  input  logic                       in_accept,
  input  rrle_pkg::in_item_t         in_item,
  output logic                       job_push,
  output rrle_pkg::job_t             job
);

  logic [rrle_pkg::NODE_W-1:0]  self_id_r, self_id_nxt;
  logic [rrle_pkg::COUNT_W-1:0] node_count_r, node_count_nxt;
  rrle_pkg::node_set_t cand_r, cand_nxt;
  rrle_pkg::node_set_t heard_r, heard_nxt;
  rrle_pkg::node_set_t part_r, part_nxt;
  logic                round_closed_r, round_closed_nxt;

  logic [rrle_pkg::COUNT_W-1:0] n_eff;
  rrle_pkg::node_set_t mask;
  rrle_pkg::node_set_t origin_hot;
  rrle_pkg::node_set_t heard_upd, cand_upd, cands, part_new;
  logic                origin_in, fwd_valid, close, single, self_part;
  logic                cls_valid;
  rrle_pkg::out_item_t fwd_item, cls_item;

  // Clamp the node count and build its mask
  always_comb begin
    n_eff = node_count_r;
    if (node_count_r < rrle_pkg::COUNT_MIN) begin
      n_eff = rrle_pkg::COUNT_MIN;
    end else if (node_count_r > rrle_pkg::COUNT_MAX) begin
      n_eff = rrle_pkg::COUNT_MAX;
    end
    mask = rrle_pkg::count_mask(n_eff);
  end

  // Record the arriving message and test for round close
  always_comb begin
    origin_hot = rrle_pkg::node_set_t'(1) << in_item.msg_origin;
    origin_in  = ({1'b0, in_item.msg_origin} < n_eff);
    heard_upd  = heard_r;
    cand_upd   = cand_r;
    if (origin_in) begin
      heard_upd = heard_r | origin_hot;
      if (in_item.msg_bit) begin
        cand_upd = cand_r | origin_hot;
      end
    end
    fwd_valid = (in_item.msg_origin != self_id_r);
    close     = !round_closed_r && (((part_r & mask) & ~(heard_upd & mask)) == '0);
    cands     = cand_upd & mask;
    single    = (cands != '0) && ((cands & (cands - 1'b1)) == '0);
    part_new  = (cands == '0) ? mask : cands;
    self_part = ({1'b0, self_id_r} < n_eff) && part_new[self_id_r];
  end

  // Build the results of this request
  always_comb begin
    fwd_item.out_kind   = rrle_pkg::KIND_MSG;
    fwd_item.out_origin = in_item.msg_origin;
    fwd_item.out_bit    = in_item.msg_bit;
    fwd_item.last       = 1'b0;
    cls_item.last       = 1'b1;
    if (single) begin
      cls_item.out_kind   = rrle_pkg::KIND_LEADER;
      cls_item.out_origin = rrle_pkg::onehot_index(cands);
      cls_item.out_bit    = 1'b0;
      cls_valid           = close;
    end else begin
      cls_item.out_kind   = rrle_pkg::KIND_MSG;
      cls_item.out_origin = self_id_r;
      cls_item.out_bit    = in_item.random_bit;
      cls_valid           = close && self_part;
    end

    job_push = 1'b0;
    job.two  = 1'b0;
    job.r0   = cls_item;
    job.r1   = cls_item;
    if (in_item.cmd == rrle_pkg::CMD_START) begin
      job.r0.out_kind   = rrle_pkg::KIND_MSG;
      job.r0.out_origin = self_id_r;
      job.r0.out_bit    = in_item.random_bit;
      job.r0.last       = 1'b1;
      job_push          = in_accept;
    end else if (fwd_valid) begin
      job.r0      = fwd_item;
      job.r0.last = !cls_valid;
      job.two     = cls_valid;
      job_push    = in_accept;
    end else begin
      job_push = in_accept && cls_valid;
    end
  end

  // Advance configuration and election state
  always_comb begin
    self_id_nxt      = self_id_r;
    node_count_nxt   = node_count_r;
    cand_nxt         = cand_r;
    heard_nxt        = heard_r;
    part_nxt         = part_r;
    round_closed_nxt = round_closed_r;
    if (cfg_we) begin
      case (cfg_index)
        rrle_pkg::CFG_SELF_ID:    self_id_nxt    = cfg_data[rrle_pkg::NODE_W-1:0];
        rrle_pkg::CFG_NODE_COUNT: node_count_nxt = cfg_data;
        default: ;
      endcase
    end
    if (in_accept && (in_item.cmd == rrle_pkg::CMD_MSG)) begin
      cand_nxt  = cand_upd;
      heard_nxt = heard_upd;
      if (close) begin
        if (single) begin
          round_closed_nxt = 1'b1;
        end else begin
          part_nxt  = part_new;
          cand_nxt  = '0;
          heard_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r      <= rrle_pkg::SELF_ID_RST;
      node_count_r   <= rrle_pkg::NODE_COUNT_RST;
      cand_r         <= '0;
      heard_r        <= '0;
      part_r         <= rrle_pkg::count_mask(rrle_pkg::NODE_COUNT_RST);
      round_closed_r <= 1'b0;
    end else begin
      self_id_r      <= self_id_nxt;
      node_count_r   <= node_count_nxt;
      cand_r         <= cand_nxt;
      heard_r        <= heard_nxt;
      part_r         <= part_nxt;
      round_closed_r <= round_closed_nxt;
    end
  end

endmodule

>>> hw/rtl/rrle_fifo.sv
// Short job queue between the front and back of the election node.
// Holds whole jobs in a small register array; uses rrle_pkg.
module rrle_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  rrle_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output rrle_pkg::job_t rd_job,
  output logic           empty
);

  rrle_pkg::job_t mem_r [rrle_pkg::JOB_DEPTH];
  logic [rrle_pkg::JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rrle_pkg::JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rrle_pkg::JOB_CNT_W-1:0] count_r, count_nxt;
  logic do_wr, do_rd;

  assign full   = (count_r == rrle_pkg::JOB_CNT_W'(rrle_pkg::JOB_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_job = mem_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> hw/rtl/rrle_back.sv
// Back end of the election node: splits jobs into single results.
// Drives the result register and holds a pending second result; uses rrle_pkg.
module rrle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  rrle_pkg::job_t      job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output rrle_pkg::out_item_t out_item
);

  logic                out_valid_r, out_valid_nxt;
  rrle_pkg::out_item_t out_item_r, out_item_nxt;
  logic                second_valid_r, second_valid_nxt;
  rrle_pkg::out_item_t second_r, second_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign out_item  = out_item_r;

  // Load the result register from the pending second result or the next job
  always_comb begin
    out_valid_nxt    = out_valid_r && !pop;
    out_item_nxt     = out_item_r;
    second_valid_nxt = second_valid_r;
    second_nxt       = second_r;
    job_pop          = 1'b0;
    if (slot_free) begin
      if (second_valid_r) begin
        out_valid_nxt    = 1'b1;
        out_item_nxt     = second_r;
        second_valid_nxt = 1'b0;
      end else if (!job_empty) begin
        out_valid_nxt    = 1'b1;
        out_item_nxt     = job.r0;
        second_valid_nxt = job.two;
        second_nxt       = job.r1;
        job_pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      second_valid_r <= 1'b0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      second_valid_r <= second_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    second_r   <= second_nxt;
  end

endmodule
